>>> hdl/brb_pkg.sv
package brb_pkg;

   // Buffer geometry.
   localparam int DEPTH    = 1024;
   localparam int MAX_READ = 64;
   localparam int PTR_W    = $clog2(DEPTH);

   // Field widths of the two channels.
   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int FILL_W   = 11;
   localparam int RLEN_W   = 7;
   localparam int STATUS_W = 3;
   localparam int OVF_W    = 32;

   // Result beat queue between the controller and the output port.
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // Request mode codes.
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_WRITE_OK  = 3'd0,
      ST_WRITE_REJ = 3'd1,
      ST_READ_DATA = 3'd2,
      ST_READ_EMPTY = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   // One result beat as it waits in the queue. Free space and the
   // empty and full flags are derived from the fill level at the port.
   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  read_byte;
      logic               run_last;
      logic [FILL_W-1:0]  fill_level;
      logic [OVF_W-1:0]   overflow_total;
   } beat_type;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

>>> hdl/brb_if.sv
interface brb_req_if;
   logic                          valid;
   logic                          ready;
   logic [brb_pkg::MODE_W-1:0]    mode;
   logic [brb_pkg::BYTE_W-1:0]    data_byte;
   logic [brb_pkg::FILL_W-1:0]    burst_length;
   logic                          burst_last;
   logic [brb_pkg::RLEN_W-1:0]    read_length;

   modport source (output valid, mode, data_byte, burst_length, burst_last, read_length,
                   input ready);
   modport sink   (input valid, mode, data_byte, burst_length, burst_last, read_length,
                   output ready);
endinterface

interface brb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brb_pkg::STATUS_W-1:0]  status;
   logic [brb_pkg::BYTE_W-1:0]    read_byte;
   logic                          run_last;
   logic [brb_pkg::FILL_W-1:0]    fill_level;
   logic [brb_pkg::FILL_W-1:0]    free_space;
   logic                          ring_empty;
   logic                          is_full;
   logic [brb_pkg::OVF_W-1:0]     overflow_total;

   modport source (output valid, status, read_byte, run_last, fill_level, free_space,
                   ring_empty, is_full, overflow_total, input ready);
   modport sink   (input valid, status, read_byte, run_last, fill_level, free_space,
                   ring_empty, is_full, overflow_total, output ready);
endinterface

>>> hdl/brb_ram.sv
module brb_ram #(
   parameter int DATA_W = 8,
   parameter int WORDS  = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(WORDS)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(WORDS)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/brb_rsp_queue.sv
module brb_rsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  brb_pkg::beat_type           push_beat,
   input  logic                        pop,
   output logic                        head_valid,
   output brb_pkg::beat_type           head_beat,
   output logic [brb_pkg::RQ_CNT_W-1:0] count
);
   import brb_pkg::*;

   beat_type              slot_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_pop;

   assign head_valid = (count_ff != '0);
   assign head_beat  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RQ_CNT_W'(push) - RQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

>>> hdl/byte_ring_buffer_burst.sv
//  Channel  | Beat direction | Contents
//  ---------+----------------+---------------------------------------------------
//  req_bus  | in             | mode, data_byte, burst_length, burst_last, read_length
//  rsp_bus  | out            | status, read_byte, run_last, fill_level, free_space,
//           |                | ring_empty, is_full, overflow_total
//
//  A write, clear or empty read is answered by one beat; a request with the unused mode
//  code is taken but answered by no beat. A read of n bytes is taken first, then fetches
//  one byte at a time through the single read port of the byte store while the result
//  queue has room, and each byte's registered read data then reaches the result queue.
//  Reset is synchronous and empties the buffer, zeroes the overflow counter and ends any
//  open burst; the byte store itself is not cleared. A stalled result port fills a
//  four-beat queue and then holds the read run and the request channel.
module byte_ring_buffer_burst (
   input  logic        clock,
   input  logic        reset,
   brb_req_if.sink     req_bus,
   brb_rsp_if.source   rsp_bus
);
   import brb_pkg::*;

   // Ring state. The byte store lives in the RAM; pointers and counts are flops.
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [OVF_W-1:0]   ovf_ff, ovf_in;
   logic               in_burst_ff, in_burst_in;
   logic               dropped_ff, dropped_in;

   // Read run sequencer: one RAM read per cycle while the queue has room, data pushed in the next cycle.
   logic               run_active_ff, run_active_in;
   logic [RLEN_W-1:0]  run_left_ff, run_left_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               pend_last_ff, pend_last_in;
   logic [FILL_W-1:0]  pend_fill_ff, pend_fill_in;

   logic               req_fire;
   logic               issue;
   logic               mem_we;
   logic               mem_re;
   logic [BYTE_W-1:0]  mem_rdata;

   logic               q_push;
   beat_type           q_push_beat;
   logic               q_head_valid;
   beat_type           q_head;
   logic [RQ_CNT_W-1:0] q_count;

   // Write-side decision for the current beat.
   logic [FILL_W-1:0]  free_now;
   logic               too_big;
   logic               drop_now;
   logic               store_now;
   logic [RLEN_W-1:0]  rlen_sat;
   logic [FILL_W-1:0]  read_n;

   brb_ram #(
      .DATA_W (BYTE_W),
      .WORDS  (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_bus.data_byte),
      .rd_en   (mem_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rdata)
   );

   brb_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_beat  (q_push_beat),
      .pop        (rsp_bus.ready),
      .head_valid (q_head_valid),
      .head_beat  (q_head),
      .count      (q_count)
   );

   // New requests wait until a read run has fully drained into the queue, so the
   // queue never sees two pushes in one cycle and the store never sees a write
   // racing an outstanding read.
   assign req_bus.ready = !run_active_ff && !rd_pend_ff && (q_count < RQ_CNT_W'(RQ_DEPTH));
   assign req_fire      = req_bus.valid && req_bus.ready;

   // A byte is fetched only when the queue is sure to have room for it next cycle,
   // counting the byte whose read data is still in flight.
   assign issue = run_active_ff &&
                  ((q_count + RQ_CNT_W'(rd_pend_ff)) < RQ_CNT_W'(RQ_DEPTH));

   assign free_now  = FILL_W'(DEPTH) - fill_ff;
   assign too_big   = (req_bus.burst_length > free_now);
   // The first byte of a burst decides for the whole burst; a zero length is dropped
   // without being counted as an overflow.
   assign drop_now  = in_burst_ff ? dropped_ff
                                  : ((req_bus.burst_length == '0) || too_big);
   assign store_now = !drop_now && (fill_ff < FILL_W'(DEPTH));

   assign rlen_sat  = (req_bus.read_length > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ)
                                                                 : req_bus.read_length;
   assign read_n    = (FILL_W'(rlen_sat) > fill_ff) ? fill_ff : FILL_W'(rlen_sat);

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      ovf_in        = ovf_ff;
      in_burst_in   = in_burst_ff;
      dropped_in    = dropped_ff;
      run_active_in = run_active_ff;
      run_left_in   = run_left_ff;
      rd_pend_in    = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_fill_in  = pend_fill_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      q_push        = 1'b0;
      q_push_beat   = '{status: ST_READ_DATA, read_byte: mem_rdata, run_last: pend_last_ff,
                        fill_level: pend_fill_ff, overflow_total: ovf_ff};

      // The byte fetched last cycle becomes a read data beat.
      if (rd_pend_ff) begin
         q_push = 1'b1;
      end

      if (issue) begin
         mem_re        = 1'b1;
         rd_ptr_in     = ptr_advance(rd_ptr_ff);
         fill_in       = fill_ff - 1'b1;
         run_left_in   = run_left_ff - 1'b1;
         run_active_in = (run_left_ff != RLEN_W'(1));
         rd_pend_in    = 1'b1;
         pend_last_in  = (run_left_ff == RLEN_W'(1));
         pend_fill_in  = fill_ff - 1'b1;
      end

      if (req_fire) begin
         unique case (req_bus.mode)
            MODE_WRITE: begin
               if (!in_burst_ff && (req_bus.burst_length != '0) && too_big) begin
                  ovf_in = ovf_ff + 1'b1;
               end
               if (store_now) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = ptr_advance(wr_ptr_ff);
                  fill_in   = fill_ff + 1'b1;
               end
               in_burst_in = !req_bus.burst_last;
               dropped_in  = req_bus.burst_last ? 1'b0 : drop_now;
               q_push      = 1'b1;
               q_push_beat = '{status: store_now ? ST_WRITE_OK : ST_WRITE_REJ,
                               read_byte: '0, run_last: 1'b1,
                               fill_level: fill_in, overflow_total: ovf_in};
            end
            MODE_READ: begin
               if (read_n == '0) begin
                  q_push      = 1'b1;
                  q_push_beat = '{status: ST_READ_EMPTY, read_byte: '0, run_last: 1'b1,
                                  fill_level: fill_ff, overflow_total: ovf_ff};
               end else begin
                  run_active_in = 1'b1;
                  run_left_in   = read_n[RLEN_W-1:0];
               end
            end
            MODE_CLEAR: begin
               wr_ptr_in   = '0;
               rd_ptr_in   = '0;
               fill_in     = '0;
               in_burst_in = 1'b0;
               dropped_in  = 1'b0;
               q_push      = 1'b1;
               q_push_beat = '{status: ST_CLEARED, read_byte: '0, run_last: 1'b1,
                               fill_level: '0, overflow_total: ovf_ff};
            end
            default: begin
               // The unused mode code is taken and produces no beat.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         ovf_ff        <= '0;
         in_burst_ff   <= 1'b0;
         dropped_ff    <= 1'b0;
         run_active_ff <= 1'b0;
         run_left_ff   <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         ovf_ff        <= ovf_in;
         in_burst_ff   <= in_burst_in;
         dropped_ff    <= dropped_in;
         run_active_ff <= run_active_in;
         run_left_ff   <= run_left_in;
         rd_pend_ff    <= rd_pend_in;
      end
      pend_last_ff <= pend_last_in;
      pend_fill_ff <= pend_fill_in;
   end

   // Output port: the queue head, with the size flags derived from its fill level.
   assign rsp_bus.valid          = q_head_valid;
   assign rsp_bus.status         = q_head.status;
   assign rsp_bus.read_byte      = q_head.read_byte;
   assign rsp_bus.run_last       = q_head.run_last;
   assign rsp_bus.fill_level     = q_head.fill_level;
   assign rsp_bus.free_space     = FILL_W'(DEPTH) - q_head.fill_level;
   assign rsp_bus.ring_empty     = (q_head.fill_level == '0);
   assign rsp_bus.is_full        = (q_head.fill_level == FILL_W'(DEPTH));
   assign rsp_bus.overflow_total = q_head.overflow_total;

   // The queue must never be pushed while it is full.
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && (q_count == RQ_CNT_W'(RQ_DEPTH))))
      else $error("result beat pushed into a full queue");

   // Every byte fetch is followed by exactly one read data beat.
   a_fetch_then_push: assert property (@(posedge clock) disable iff (reset)
      issue |=> (q_push && (q_push_beat.status == ST_READ_DATA)))
      else $error("fetched byte did not reach the result queue");

   // The fill level stays within the capacity of the store.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill level beyond capacity");

   // The final fetch of a run ends the run on the next cycle.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && (run_left_ff == RLEN_W'(1))) |=> !run_active_ff)
      else $error("read run did not end after its last byte");

endmodule
